// ===== sv/wpc_pkg.sv =====
// Package: shared constants, types and the divider request and status for the chime block.
package wpc_pkg;

    // Field and register widths
    localparam int CMD_W      = 1;
    localparam int WDAY_W     = 3;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int MODE_W     = 2;
    localparam int MASK_W     = 7;
    localparam int MOD_W      = 11;
    localparam int PULSE_W    = 8;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Blink length and its counter width
    localparam int BLINK_STEPS = 10;
    localparam int STEP_W      = $clog2(BLINK_STEPS + 1);

    // Divider step count and counter width
    localparam int DIV_STEPS = MOD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Constants of the time arithmetic
    localparam logic [MOD_W-1:0] MIN_PER_HOUR = MOD_W'(60);
    localparam logic [MOD_W-1:0] DEF_INTERVAL = MOD_W'(30);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_MINUTE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SECOND = 1'b1;

    // Chime modes
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HOURLY = 2'd1;

    // Pulse pattern codes and reported kinds
    localparam logic [PULSE_W-1:0] PULSE_DOUBLE = 8'd1;
    localparam logic [PULSE_W-1:0] PULSE_LONG   = 8'd2;
    localparam logic [KIND_W-1:0]  KIND_SHORT   = 2'd0;
    localparam logic [KIND_W-1:0]  KIND_DOUBLE  = 2'd1;
    localparam logic [KIND_W-1:0]  KIND_LONG    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WSTART   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEND     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IGNQUIET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE    = 3'd6;

    // Request to the remainder unit
    typedef struct packed {
        logic             start;
        logic [MOD_W-1:0] dividend;
        logic [MOD_W-1:0] divisor;
    } t_div_req;

    // Status back from the remainder unit
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MOD_W-1:0] rem;
    } t_div_stat;

endpackage

// ===== sv/wpc_mod.sv =====
// Remainder unit: restoring division, one quotient bit per cycle.
module wpc_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wpc_pkg::t_div_req i_req,
    output wpc_pkg::t_div_stat o_stat
);
    import wpc_pkg::*;

    logic [MOD_W-1:0]     r_num, n_num;
    logic [MOD_W-1:0]     r_rem, n_rem;
    logic [MOD_W-1:0]     r_div, n_div;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [MOD_W:0]       w_trial;
    logic [MOD_W:0]       w_diff;

    // Shift in the next dividend bit and try the subtract
    assign w_trial = {r_rem, r_num[MOD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_num  = i_req.dividend;
            n_div  = i_req.divisor;
            n_rem  = '0;
            n_cnt  = DIV_CNT_W'(DIV_STEPS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // Keep the difference when the trial is not below the divisor
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_diff[MOD_W-1:0];
            end else begin
                n_rem = w_trial[MOD_W-1:0];
            end
            n_num = {r_num[MOD_W-2:0], 1'b0};
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;

endmodule

// ===== sv/windowed_periodic_chime_with_blink.sv =====
// Top level: chime decision, blink sequencer, configuration and output register.
// Minute tick: from accept the request passes S_CALC (11 remainder steps in wpc_mod), then S_WRITE.
// Second tick: from accept it goes straight to S_WRITE; no remainder work.
// One request at a time: a new tick is accepted only in S_IDLE, once the last one is written;
// the next may be accepted while a result waits to be taken.
// Reset (synchronous, active low) restores the register defaults and clears the blink.
module windowed_periodic_chime_with_blink (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [wpc_pkg::CMD_W-1:0]      i_cmd,
    input  logic [wpc_pkg::WDAY_W-1:0]     i_weekday,
    input  logic [wpc_pkg::HOUR_W-1:0]     i_hour,
    input  logic [wpc_pkg::MIN_W-1:0]      i_minute,
    input  logic                           i_quiet_now,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_chime_fired,
    output logic [wpc_pkg::KIND_W-1:0]     o_pattern_kind,
    output logic                           o_blink_active,
    output logic                           o_blink_inverted,
    output logic                           o_marks_hour_hand,
    output logic                           o_redraw_notice
);
    import wpc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_WRITE} t_state;

    // Configuration registers
    logic [MODE_W-1:0]  r_mode;
    logic [MASK_W-1:0]  r_mask;
    logic [MOD_W-1:0]   r_wstart;
    logic [MOD_W-1:0]   r_wend;
    logic [MOD_W-1:0]   r_interval;
    logic               r_ign_quiet;
    logic [PULSE_W-1:0] r_pulse;

    // Captured request
    t_state             r_state;
    logic [CMD_W-1:0]   r_cmd;
    logic [WDAY_W-1:0]  r_wday;
    logic [MIN_W-1:0]   r_minute;
    logic               r_quiet;
    logic [MOD_W-1:0]   r_mod;

    // Blink state
    logic               r_blink_on, n_blink_on;
    logic               r_blink_phase, n_blink_phase;
    logic [STEP_W-1:0]  r_blink_steps, n_blink_steps;
    logic               r_hour_flag, n_hour_flag;

    // Output register
    logic               r_out_valid;
    logic               r_fired, n_fired;
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic               r_redraw, n_redraw;

    logic               w_accept;
    logic [MOD_W-1:0]   w_mod_in;
    logic [MOD_W-1:0]   w_ival;
    logic               w_in_window;
    logic               w_cadence;
    logic               w_ok;
    logic [STEP_W-1:0]  w_step_inc;
    logic               w_out_free;
    t_div_req           w_req;
    t_div_stat          w_stat;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Minute of day: hour*60 as (hour<<6) - (hour<<2), plus minute
    assign w_mod_in = (MOD_W'(i_hour) << 6) - (MOD_W'(i_hour) << 2) + MOD_W'(i_minute);
    assign w_ival   = (r_interval != '0) ? r_interval : DEF_INTERVAL;

    // Launch the remainder on a minute tick
    assign w_req.start    = w_accept && (i_cmd == CMD_MINUTE);
    assign w_req.dividend = w_mod_in;
    assign w_req.divisor  = w_ival;

    wpc_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_stat  (w_stat)
    );

    // Window test, inclusive ends, wrapping when start exceeds end; equal ends match every minute
    always_comb begin
        priority if (r_wstart == r_wend) begin
            w_in_window = 1'b1;
        end else if (r_wstart < r_wend) begin
            w_in_window = (r_mod >= r_wstart) && (r_mod <= r_wend);
        end else begin
            w_in_window = (r_mod >= r_wstart) || (r_mod <= r_wend);
        end
    end

    assign w_cadence = (r_mode == MODE_HOURLY) ? (r_minute == '0) : (w_stat.rem == '0);
    assign w_ok = (r_mode != MODE_OFF) && r_mask[r_wday] && (r_wday < WDAY_W'(MASK_W))
                  && w_in_window && w_cadence && (r_ign_quiet || !r_quiet);
    assign w_step_inc = r_blink_steps + STEP_W'(1);

    // Next blink state and result for the captured request
    always_comb begin
        n_blink_on    = r_blink_on;
        n_blink_phase = r_blink_phase;
        n_blink_steps = r_blink_steps;
        n_hour_flag   = r_hour_flag;
        n_fired       = 1'b0;
        n_kind        = KIND_SHORT;
        n_redraw      = 1'b0;
        if (r_cmd == CMD_SECOND) begin
            if (r_blink_on) begin
                n_blink_steps = w_step_inc;
                if (w_step_inc >= STEP_W'(BLINK_STEPS)) begin
                    n_blink_on    = 1'b0;
                    n_blink_phase = 1'b0;
                end else begin
                    n_blink_phase = !r_blink_phase;
                end
                n_redraw = 1'b1;
            end
        end else if (w_ok) begin
            n_fired = 1'b1;
            priority if (r_pulse == PULSE_DOUBLE) begin
                n_kind = KIND_DOUBLE;
            end else if (r_pulse == PULSE_LONG) begin
                n_kind = KIND_LONG;
            end else begin
                n_kind = KIND_SHORT;
            end
            n_blink_on    = 1'b1;
            n_blink_phase = 1'b1;
            n_blink_steps = '0;
            n_hour_flag   = (r_mode == MODE_HOURLY) || (w_ival == MIN_PER_HOUR);
            n_redraw      = 1'b1;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_mask      <= '1;
            r_wstart    <= '0;
            r_wend      <= '0;
            r_interval  <= DEF_INTERVAL;
            r_ign_quiet <= 1'b0;
            r_pulse     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:     r_mode      <= i_cfg_data[MODE_W-1:0];
                REG_MASK:     r_mask      <= i_cfg_data[MASK_W-1:0];
                REG_WSTART:   r_wstart    <= i_cfg_data[MOD_W-1:0];
                REG_WEND:     r_wend      <= i_cfg_data[MOD_W-1:0];
                REG_INTERVAL: r_interval  <= i_cfg_data[MOD_W-1:0];
                REG_IGNQUIET: r_ign_quiet <= i_cfg_data[0];
                REG_PULSE:    r_pulse     <= i_cfg_data[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the request fields
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_cmd;
            r_wday   <= i_weekday;
            r_minute <= i_minute;
            r_quiet  <= i_quiet_now;
            r_mod    <= w_mod_in;
        end
    end

    // Sequencer, blink state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_blink_on    <= 1'b0;
            r_blink_phase <= 1'b0;
            r_blink_steps <= '0;
            r_hour_flag   <= 1'b0;
        end else begin
            // Drop the result once taken, unless the next one replaces it
            if (r_out_valid && i_out_ready && (r_state != S_WRITE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= (i_cmd == CMD_MINUTE) ? S_CALC : S_WRITE;
                    end
                end
                S_CALC: begin
                    if (w_stat.done) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    // Hold until the output register is free
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_fired       <= n_fired;
                        r_kind        <= n_kind;
                        r_redraw      <= n_redraw;
                        r_blink_on    <= n_blink_on;
                        r_blink_phase <= n_blink_phase;
                        r_blink_steps <= n_blink_steps;
                        r_hour_flag   <= n_hour_flag;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_chime_fired     = r_fired;
    assign o_pattern_kind    = r_kind;
    assign o_blink_active    = r_blink_on;
    assign o_blink_inverted  = r_blink_on && r_blink_phase;
    assign o_marks_hour_hand = r_hour_flag;
    assign o_redraw_notice   = r_redraw;

    // A fired chime always starts a fresh, inverted blink and asks for a redraw
    a_fire_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_chime_fired) |-> (o_blink_inverted && o_redraw_notice))
        else $error("chime fired without starting the blink");

    // No pattern kind without a chime
    a_kind_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_chime_fired) |-> (o_pattern_kind == KIND_SHORT))
        else $error("pattern kind reported without a chime");

    // The remainder unit is never busy while a new request can be taken
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_stat.busy)
        else $error("remainder unit busy while accepting");

    // A minute tick never produces its result before the remainder finishes
    a_calc_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC && !w_stat.done) |=> (r_state == S_CALC))
        else $error("left calculation before remainder done");

endmodule
